### src/ildr_pkg.sv
package ildr_pkg;

  // lane count of the datapath and the lanes that the packed bytes can feed
  localparam int LANES     = 8;
  localparam int LANE_USE  = (LANES < 8) ? LANES : 8;
  localparam int CNT_W     = 4;

  // lane product and merged sum widths
  localparam int PROD_W    = 20;
  localparam int SUM_W     = PROD_W + $clog2(LANE_USE) + 1;

  // requantizer constants
  localparam logic signed [63:0] ROUND_Q31 = 64'sd1 << 30;
  localparam logic signed [31:0] MULT_RESET = 32'sd1073741824;

  // configuration port
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  typedef logic signed [PROD_W-1:0] ildr_prod_t;
  typedef logic signed [SUM_W-1:0]  ildr_sum_t;

  typedef enum logic [2:0] {
    REG_ACT_OFFSET    = 3'd0,
    REG_WEIGHT_OFFSET = 3'd1,
    REG_RESULT_OFFSET = 3'd2,
    REG_SCALE_MULT    = 3'd3,
    REG_SCALE_SHIFT   = 3'd4,
    REG_CLAMP_LOW     = 3'd5,
    REG_CLAMP_HIGH    = 3'd6
  } ildr_reg_e;

  typedef struct packed {
    logic signed [8:0]  act_offset;
    logic signed [8:0]  weight_offset;
    logic signed [8:0]  result_offset;
    logic signed [31:0] scale_multiplier;
    logic signed [5:0]  scale_shift;
    logic signed [7:0]  clamp_low;
    logic signed [7:0]  clamp_high;
  } ildr_cfg_t;

  // per item control that travels with the data
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } ildr_ctl_t;

endpackage

### src/ildr_lane.sv
module ildr_lane import ildr_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             active_i,
  input  logic [7:0]       in_byte_i,
  input  logic [7:0]       wt_byte_i,
  input  logic signed [8:0] act_offset_i,
  input  logic signed [8:0] weight_offset_i,
  output ildr_prod_t       prod_o
);

  logic signed [9:0] x_off;
  logic signed [9:0] w_off;
  ildr_prod_t        prod_d;
  ildr_prod_t        prod_q;

  // offset both bytes, multiply, zero for lanes past the count
  always_comb begin
    x_off  = 10'(signed'(in_byte_i)) + 10'(act_offset_i);
    w_off  = 10'(signed'(wt_byte_i)) + 10'(weight_offset_i);
    prod_d = active_i ? PROD_W'(x_off * w_off) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

### src/ildr_merge.sv
module ildr_merge import ildr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  ildr_ctl_t          ctl_i,
  input  logic signed [31:0] bias_i,
  input  ildr_prod_t         prods_i [LANE_USE],
  output logic               sum_valid_o,
  output logic signed [31:0] sum_o
);

  ildr_ctl_t          s1_ctl_q, s2_ctl_q;
  logic signed [31:0] s1_bias_q, s2_bias_q;
  ildr_sum_t          tree_d, s2_sum_q;
  logic signed [31:0] acc_d, acc_q;
  logic               done_q;

  // merge the lane products
  always_comb begin
    tree_d = '0;
    for (int k = 0; k < LANE_USE; k++) begin
      tree_d = tree_d + SUM_W'(prods_i[k]);
    end
  end

  // running sum, loads the bias on a first group
  always_comb begin
    acc_d = (s2_ctl_q.first ? s2_bias_q : acc_q) + 32'(s2_sum_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      acc_q    <= '0;
      done_q   <= 1'b0;
    end else if (en_i) begin
      s1_ctl_q <= ctl_i;
      s2_ctl_q <= s1_ctl_q;
      done_q   <= s2_ctl_q.valid & s2_ctl_q.last;
      if (s2_ctl_q.valid) begin
        acc_q <= acc_d;
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_bias_q <= bias_i;
      s2_bias_q <= s1_bias_q;
      s2_sum_q  <= tree_d;
    end
  end

  assign sum_valid_o = done_q;
  assign sum_o       = acc_q;

endmodule

### src/ildr_requant.sv
module ildr_requant import ildr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  ildr_cfg_t          cfg_i,
  input  logic               valid_i,
  input  logic signed [31:0] sum_i,
  output logic               valid_o,
  output logic signed [7:0]  value_o
);

  logic               s4_valid_q, s5_valid_q, s6_valid_q, s7_valid_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] rounded;
  logic [31:0]        scaled_q;
  logic [4:0]         rsh;
  logic [5:0]         lsh;
  logic signed [32:0] rnd_v;
  logic signed [32:0] rsh_v;
  logic [31:0]        shifted_d, shifted_q;
  logic signed [31:0] offs_v;
  logic signed [31:0] clamp_v;
  logic signed [7:0]  value_q;

  // q31 rounding of the product
  assign rounded = prod_q + ROUND_Q31;

  // rounded right shift or wrapping left shift
  always_comb begin
    rsh       = cfg_i.scale_shift[4:0];
    lsh       = 6'(-cfg_i.scale_shift);
    rnd_v     = 33'({32'd0, 1'b1} << (rsh - 5'd1));
    rsh_v     = (signed'({scaled_q[31], scaled_q}) + rnd_v) >>> rsh;
    shifted_d = scaled_q;
    if (!cfg_i.scale_shift[5] && (cfg_i.scale_shift != 6'sd0)) begin
      shifted_d = rsh_v[31:0];
    end else if (cfg_i.scale_shift[5]) begin
      shifted_d = scaled_q << lsh;
    end
  end

  // output offset and clamp, the upper bound wins when crossed
  always_comb begin
    offs_v  = signed'(shifted_q) + 32'(cfg_i.result_offset);
    clamp_v = offs_v;
    if (clamp_v < 32'(cfg_i.clamp_low)) begin
      clamp_v = 32'(cfg_i.clamp_low);
    end
    if (clamp_v > 32'(cfg_i.clamp_high)) begin
      clamp_v = 32'(cfg_i.clamp_high);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
    end else if (en_i) begin
      s4_valid_q <= valid_i;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
      s7_valid_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= 64'(sum_i) * 64'(cfg_i.scale_multiplier);
      scaled_q  <= rounded[62:31];
      shifted_q <= shifted_d;
      value_q   <= clamp_v[7:0];
    end
  end

  assign valid_o = s7_valid_q;
  assign value_o = value_q;

endmodule

### src/int8_linear_dot_requantize.sv
// a last_group item passes the lane, merge, accumulate and requantize registers to out_valid_o
// throughput: one item per cycle; the whole pipeline holds while a result is stalled
// the running sum feedback sits in a single accumulate stage, so items may follow back to back
// reset: valid bits and the running sum clear, configuration registers take their defaults
module int8_linear_dot_requantize import ildr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                first_group_i,
  input  logic                last_group_i,
  input  logic signed [31:0]  bias_i,
  input  logic [63:0]         input_bytes_i,
  input  logic [63:0]         weight_bytes_i,
  input  logic [CNT_W-1:0]    lane_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [7:0]   out_value_o
);

  ildr_cfg_t          cfg_q;
  ildr_ctl_t          in_ctl;
  ildr_prod_t         prods [LANE_USE];
  logic               adv;
  logic               sum_valid;
  logic signed [31:0] sum;
  logic               cfg_wr;
  ildr_reg_e          reg_idx;

  // pipeline advances unless a finished result is held
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  assign in_ctl.valid = in_valid_i;
  assign in_ctl.first = first_group_i;
  assign in_ctl.last  = last_group_i;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = ildr_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.act_offset       <= '0;
      cfg_q.weight_offset    <= '0;
      cfg_q.result_offset    <= '0;
      cfg_q.scale_multiplier <= MULT_RESET;
      cfg_q.scale_shift      <= '0;
      cfg_q.clamp_low        <= -8'sd128;
      cfg_q.clamp_high       <= 8'sd127;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ACT_OFFSET:    cfg_q.act_offset       <= pwdata[8:0];
        REG_WEIGHT_OFFSET: cfg_q.weight_offset    <= pwdata[8:0];
        REG_RESULT_OFFSET: cfg_q.result_offset    <= pwdata[8:0];
        REG_SCALE_MULT:    cfg_q.scale_multiplier <= pwdata[31:0];
        REG_SCALE_SHIFT:   cfg_q.scale_shift      <= pwdata[5:0];
        REG_CLAMP_LOW:     cfg_q.clamp_low        <= pwdata[7:0];
        REG_CLAMP_HIGH:    cfg_q.clamp_high       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback, sign extended
  always_comb begin
    case (reg_idx)
      REG_ACT_OFFSET:    prdata = DATA_W'(cfg_q.act_offset);
      REG_WEIGHT_OFFSET: prdata = DATA_W'(cfg_q.weight_offset);
      REG_RESULT_OFFSET: prdata = DATA_W'(cfg_q.result_offset);
      REG_SCALE_MULT:    prdata = DATA_W'(cfg_q.scale_multiplier);
      REG_SCALE_SHIFT:   prdata = DATA_W'(cfg_q.scale_shift);
      REG_CLAMP_LOW:     prdata = DATA_W'(cfg_q.clamp_low);
      REG_CLAMP_HIGH:    prdata = DATA_W'(cfg_q.clamp_high);
      default:           prdata = '0;
    endcase
  end

  // multiply lanes
  for (genvar k = 0; k < LANE_USE; k++) begin : g_lane
    ildr_lane u_lane (
      .clk_i           (clk_i),
      .en_i            (adv),
      .active_i        (lane_count_i > CNT_W'(k)),
      .in_byte_i       (input_bytes_i[8*k +: 8]),
      .wt_byte_i       (weight_bytes_i[8*k +: 8]),
      .act_offset_i    (cfg_q.act_offset),
      .weight_offset_i (cfg_q.weight_offset),
      .prod_o          (prods[k])
    );
  end

  // merge tree and accumulator
  ildr_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .ctl_i       (in_ctl),
    .bias_i      (bias_i),
    .prods_i     (prods),
    .sum_valid_o (sum_valid),
    .sum_o       (sum)
  );

  // requantize and clamp
  ildr_requant u_requant (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .cfg_i   (cfg_q),
    .valid_i (sum_valid),
    .sum_i   (sum),
    .valid_o (out_valid_o),
    .value_o (out_value_o)
  );

endmodule

### src/ildr_checker.sv
module ildr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic signed [7:0] out_value_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_value_o))
    else $error("result changed while stalled");

  // input side holds only while a result is held at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output hold");

  // no result right out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result offered right after reset");

endmodule

bind int8_linear_dot_requantize ildr_checker u_ildr_checker (.*);
